### hw/rtl/rxrb_pkg.sv
`timescale 1ns / 1ps

package rxrb_pkg;

    // Ring geometry
    localparam int DEPTH    = 256;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int MAX_READ = 64;

    localparam logic [7:0] TERM_RESET = 8'd10;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_READ   = 2'd1,
        CMD_LINE   = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH_WR,
        ST_READ,
        ST_RECOUNT
    } state_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] rx_byte;
        logic [6:0] max_len;
    } req_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last;
        logic [8:0] fill_count;
        logic       line_ready;
    } rsp_item_t;

    // Advance a slot index by one with wrap
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1)) begin
            res = '0;
        end
        else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

    // Slot index plus a count, modulo the depth
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(idx) + (CNT_W + 1)'(cnt);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

endpackage

### hw/rtl/rxrb_ram.sv
`timescale 1ns / 1ps

module rxrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/rx_ring_buffer_with_line_detect.sv
`timescale 1ns / 1ps

// Receive ring buffer for one serial channel, bytes held in one synchronous RAM of
// rxrb_pkg::DEPTH entries. A push to a full buffer first reads the oldest slot to
// update the terminator count, then overwrites it. A status query or an empty read is
// answered from the idle state. A read of n bytes waits for the registered RAM read and
// then returns one byte per cycle while the result side does not stall. Writing the
// line terminator starts a recount that reads every held byte from the RAM, during
// which no item is taken. A result may sit in the output register while the next item
// is accepted.
module rx_ring_buffer_with_line_detect #(
    parameter int MAX_READ = rxrb_pkg::MAX_READ
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  rxrb_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rxrb_pkg::rsp_item_t rsp_item,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata
);

    localparam int IDX_W = rxrb_pkg::IDX_W;
    localparam int CNT_W = rxrb_pkg::CNT_W;

    rxrb_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] tc_reg, tc_next;
    logic [7:0]       term_reg, term_next;

    rxrb_pkg::cmd_t   cmd_reg, cmd_next;
    logic [6:0]       limit_reg, limit_next;
    logic [6:0]       n_reg, n_next;
    logic [7:0]       rx_reg, rx_next;

    logic [IDX_W-1:0] rc_idx_reg, rc_idx_next;
    logic [CNT_W-1:0] rc_left_reg, rc_left_next;
    logic             rc_pend_reg, rc_pend_next;

    logic                rsp_valid_reg, rsp_valid_next;
    rxrb_pkg::rsp_item_t rsp_reg, rsp_next;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;

    logic             rsp_free, accept, full;
    logic [6:0]       limit_in;
    logic             rd_is_term, rd_stop;
    logic [CNT_W-1:0] rd_count, rd_tc;

    rxrb_ram #(
        .WIDTH (8),
        .DEPTH (rxrb_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and shared decode
    always_comb
    begin
        rsp_free  = !rsp_valid_reg || !rsp_stall;
        req_stall = (state_reg != rxrb_pkg::ST_IDLE) || !rsp_free || cfg_we;
        accept    = req_valid && !req_stall;
        full      = (count_reg == CNT_W'(rxrb_pkg::DEPTH));
        if ({1'b0, req_item.max_len} > 8'(MAX_READ))
        begin
            limit_in = 7'(MAX_READ);
        end
        else
        begin
            limit_in = req_item.max_len;
        end
    end

    // Byte taken on a read: terminator test and stop condition
    always_comb
    begin
        rd_is_term = (ram_rdata == term_reg);
        rd_count   = count_reg - CNT_W'(1);
        rd_tc      = tc_reg;
        if (rd_is_term && (tc_reg != '0))
        begin
            rd_tc = tc_reg - CNT_W'(1);
        end
        rd_stop = ((cmd_reg == rxrb_pkg::CMD_LINE) && rd_is_term) || (rd_count == '0) ||
                  (({1'b0, n_reg} + 8'd1) >= {1'b0, limit_reg});
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rxrb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_item.cmd)
                        rxrb_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                state_next = rxrb_pkg::ST_PUSH_WR;
                            end
                        end
                        rxrb_pkg::CMD_READ, rxrb_pkg::CMD_LINE:
                        begin
                            if ((limit_in != '0) && (count_reg != '0))
                            begin
                                state_next = rxrb_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = rxrb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rxrb_pkg::ST_PUSH_WR:
            begin
                state_next = rxrb_pkg::ST_IDLE;
            end
            rxrb_pkg::ST_READ:
            begin
                if (rsp_free && rd_stop)
                begin
                    state_next = rxrb_pkg::ST_IDLE;
                end
            end
            rxrb_pkg::ST_RECOUNT:
            begin
                if ((rc_left_reg == '0) && !rc_pend_reg)
                begin
                    state_next = rxrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rxrb_pkg::ST_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            state_next = rxrb_pkg::ST_RECOUNT;
        end
    end

    // Datapath, RAM access and result loading
    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        count_next     = count_reg;
        tc_next        = tc_reg;
        term_next      = term_reg;
        cmd_next       = cmd_reg;
        limit_next     = limit_reg;
        n_next         = n_reg;
        rx_next        = rx_reg;
        rc_idx_next    = rc_idx_reg;
        rc_left_next   = rc_left_reg;
        rc_pend_next   = rc_pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = rd_idx_reg;
        ram_wdata      = rx_reg;
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg;

        case (state_reg)
            rxrb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // Status result unless a read or a full-buffer push starts
                    rsp_valid_next      = 1'b1;
                    rsp_next.data_byte  = 8'd0;
                    rsp_next.data_valid = 1'b0;
                    rsp_next.last       = 1'b1;
                    rsp_next.fill_count = 9'(count_reg);
                    rsp_next.line_ready = (tc_reg != '0);
                    case (req_item.cmd)
                        rxrb_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                // Fetch the oldest byte before overwriting it
                                ram_re         = 1'b1;
                                rx_next        = req_item.rx_byte;
                                rsp_valid_next = 1'b0;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = rxrb_pkg::idx_add(rd_idx_reg, count_reg);
                                ram_wdata  = req_item.rx_byte;
                                count_next = count_reg + CNT_W'(1);
                                if (req_item.rx_byte == term_reg)
                                begin
                                    tc_next = tc_reg + CNT_W'(1);
                                end
                                rsp_next.fill_count = 9'(count_next);
                                rsp_next.line_ready = (tc_next != '0);
                            end
                        end
                        rxrb_pkg::CMD_READ, rxrb_pkg::CMD_LINE:
                        begin
                            if ((limit_in != '0) && (count_reg != '0))
                            begin
                                ram_re         = 1'b1;
                                cmd_next       = req_item.cmd;
                                limit_next     = limit_in;
                                n_next         = '0;
                                rsp_valid_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            rxrb_pkg::ST_PUSH_WR:
            begin
                // Drop the oldest byte and store the new one in its slot
                if ((ram_rdata == term_reg) && (tc_reg != '0))
                begin
                    tc_next = tc_reg - CNT_W'(1);
                end
                if (rx_reg == term_reg)
                begin
                    tc_next = tc_next + CNT_W'(1);
                end
                ram_we              = 1'b1;
                ram_waddr           = rd_idx_reg;
                ram_wdata           = rx_reg;
                rd_idx_next         = rxrb_pkg::idx_inc(rd_idx_reg);
                rsp_valid_next      = 1'b1;
                rsp_next.data_byte  = 8'd0;
                rsp_next.data_valid = 1'b0;
                rsp_next.last       = 1'b1;
                rsp_next.fill_count = 9'(count_reg);
                rsp_next.line_ready = (tc_next != '0);
            end
            rxrb_pkg::ST_READ:
            begin
                if (rsp_free)
                begin
                    // Emit the fetched byte and fetch the next one
                    rd_idx_next         = rxrb_pkg::idx_inc(rd_idx_reg);
                    count_next          = rd_count;
                    tc_next             = rd_tc;
                    rsp_valid_next      = 1'b1;
                    rsp_next.data_byte  = ram_rdata;
                    rsp_next.data_valid = 1'b1;
                    rsp_next.last       = rd_stop;
                    rsp_next.fill_count = 9'(rd_count);
                    rsp_next.line_ready = (rd_tc != '0);
                    if (!rd_stop)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = rd_idx_next;
                        n_next    = n_reg + 7'd1;
                    end
                end
            end
            rxrb_pkg::ST_RECOUNT:
            begin
                // Count terminators over the held bytes, one read per cycle
                if (rc_pend_reg && (ram_rdata == term_reg))
                begin
                    tc_next = tc_reg + CNT_W'(1);
                end
                if (rc_left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = rc_idx_reg;
                    rc_idx_next  = rxrb_pkg::idx_inc(rc_idx_reg);
                    rc_left_next = rc_left_reg - CNT_W'(1);
                    rc_pend_next = 1'b1;
                end
                else
                begin
                    rc_pend_next = 1'b0;
                end
            end
            default:
            begin
                rc_pend_next = 1'b0;
            end
        endcase

        // New terminator: restart the recount from the oldest byte
        if (cfg_we)
        begin
            term_next    = cfg_wdata;
            tc_next      = '0;
            rc_idx_next  = rd_idx_reg;
            rc_left_next = count_reg;
            rc_pend_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rxrb_pkg::ST_IDLE;
            rd_idx_reg    <= '0;
            count_reg     <= '0;
            tc_reg        <= '0;
            term_reg      <= rxrb_pkg::TERM_RESET;
            cmd_reg       <= rxrb_pkg::CMD_STATUS;
            limit_reg     <= '0;
            n_reg         <= '0;
            rc_idx_reg    <= '0;
            rc_left_reg   <= '0;
            rc_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            count_reg     <= count_next;
            tc_reg        <= tc_next;
            term_reg      <= term_next;
            cmd_reg       <= cmd_next;
            limit_reg     <= limit_next;
            n_reg         <= n_next;
            rc_idx_reg    <= rc_idx_next;
            rc_left_reg   <= rc_left_next;
            rc_pend_reg   <= rc_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rx_reg  <= rx_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

endmodule

### hw/rtl/rxrb_checker.sv
`timescale 1ns / 1ps

module rxrb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input rxrb_pkg::rsp_item_t rsp_item
);

    // A stalled result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("stalled result changed");

    // A status-only result always closes its item
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.data_valid |-> rsp_item.last && (rsp_item.data_byte == 8'd0))
        else $error("status result not last");

    // Fill count never exceeds the ring depth
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_item.fill_count <= 9'(rxrb_pkg::DEPTH))
        else $error("fill count above depth");

    // A stored terminator implies a non-empty buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.line_ready |-> rsp_item.fill_count != 9'd0)
        else $error("line flagged with empty buffer");

    // An item is only taken when no result is stuck in the output
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> !(rsp_valid && rsp_stall))
        else $error("item accepted while result blocked");

endmodule

bind rx_ring_buffer_with_line_detect rxrb_checker u_rxrb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    bit                  clk;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    rxrb_pkg::req_item_t req_item  = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rxrb_pkg::rsp_item_t rsp_item;
    logic                cfg_we    = 1'b0;
    logic [7:0]          cfg_wdata = '0;

    // Commands waiting to be offered, and responses owed by the ring
    rxrb_pkg::req_item_t cmd_feed_q[$];
    rxrb_pkg::rsp_item_t ring_rsp_q[$];

    // Shadow of the ring contents and counters
    logic [7:0]  shadow_mem[rxrb_pkg::DEPTH];
    logic [7:0]  shadow_head;
    int          shadow_held;
    int          shadow_terms;
    logic [7:0]  shadow_term;

    int          snd_idle_pct;
    int          rcv_idle_pct;
    bit          hold_req;
    int          hold_left;
    bit          item_taken;
    int          err_cnt;
    int          cycle_cnt;
    int          items_taken;
    int          rsp_seen;
    int          bytes_seen;
    int          overwrites;
    int          peak_fill;
    logic [7:0]  last_term;
    rxrb_pkg::rsp_item_t got_rsp;
    rxrb_pkg::rsp_item_t want_rsp;

    rx_ring_buffer_with_line_detect u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Queue one owed response from the shadow state
    function automatic void owe_rsp(logic [7:0] b, logic dv, logic lst);
        rxrb_pkg::rsp_item_t r;
        r.data_byte  = b;
        r.data_valid = dv;
        r.last       = lst;
        r.fill_count = 9'(shadow_held);
        r.line_ready = (shadow_terms != 0);
        ring_rsp_q.push_back(r);
    endfunction

    // Recount held terminators against a new terminator value
    function automatic void retally_terms(logic [7:0] term);
        shadow_term  = term;
        shadow_terms = 0;
        for (int i = 0; i < shadow_held; i++)
        begin
            if (shadow_mem[8'(shadow_head + 8'(i))] == term)
                shadow_terms++;
        end
    endfunction

    // Apply one accepted command to the shadow ring and owe its responses
    function automatic void ring_apply_cmd(rxrb_pkg::req_item_t it);
        int         limit;
        int         n;
        logic [7:0] b;
        bit         is_term;
        bit         stop;
        limit = (it.max_len > 7'(rxrb_pkg::MAX_READ)) ? rxrb_pkg::MAX_READ
                                                      : int'(it.max_len);
        n     = 0;
        if (it.cmd == rxrb_pkg::CMD_PUSH)
        begin
            if (shadow_held >= rxrb_pkg::DEPTH)
            begin
                // drop the oldest byte to make room
                if (shadow_mem[shadow_head] == shadow_term && shadow_terms > 0)
                    shadow_terms--;
                shadow_mem[shadow_head] = it.rx_byte;
                shadow_head++;
                overwrites++;
            end
            else
            begin
                shadow_mem[8'(shadow_head + 8'(shadow_held))] = it.rx_byte;
                shadow_held++;
            end
            if (it.rx_byte == shadow_term)
                shadow_terms++;
            if (shadow_held > peak_fill)
                peak_fill = shadow_held;
            owe_rsp(8'h00, 1'b0, 1'b1);
        end
        else
        begin
            if (it.cmd == rxrb_pkg::CMD_READ || it.cmd == rxrb_pkg::CMD_LINE)
            begin
                while (shadow_held > 0 && n < limit)
                begin
                    b       = shadow_mem[shadow_head];
                    is_term = (b == shadow_term);
                    shadow_head++;
                    shadow_held--;
                    if (is_term && shadow_terms > 0)
                        shadow_terms--;
                    stop = (it.cmd == rxrb_pkg::CMD_LINE && is_term) || shadow_held == 0
                           || n + 1 >= limit;
                    owe_rsp(b, 1'b1, stop);
                    n++;
                    if (stop)
                        break;
                end
            end
            if (n == 0)
                owe_rsp(8'h00, 1'b0, 1'b1);
        end
    endfunction

    task automatic cmp_field(string fname, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            err_cnt++;
        end
    endtask

    // Track register writes, accepted commands and returned responses
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                retally_terms(cfg_wdata);
            if (req_valid && !req_stall)
            begin
                ring_apply_cmd(req_item);
                void'(cmd_feed_q.pop_front());
                item_taken = 1'b1;
                items_taken++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                got_rsp = rsp_item;
                rsp_seen++;
                if (ring_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %h", $time, got_rsp);
                    err_cnt++;
                end
                else
                begin
                    want_rsp = ring_rsp_q.pop_front();
                    if (got_rsp.data_valid)
                        bytes_seen++;
                    cmp_field("data_byte", want_rsp.data_byte, got_rsp.data_byte);
                    cmp_field("data_valid", want_rsp.data_valid, got_rsp.data_valid);
                    cmp_field("last", want_rsp.last, got_rsp.last);
                    cmp_field("fill_count", want_rsp.fill_count, got_rsp.fill_count);
                    cmp_field("line_ready", want_rsp.line_ready, got_rsp.line_ready);
                end
            end
        end
    end

    // Offer commands; hold a stalled item until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (req_valid && !item_taken)
            req_valid <= 1'b1;
        else if (cmd_feed_q.size() > 0 && $urandom_range(99) >= snd_idle_pct)
        begin
            req_valid <= 1'b1;
            req_item  <= cmd_feed_q[0];
        end
        else
            req_valid <= 1'b0;
        item_taken = 1'b0;
    end

    // Stall responses at random, or for one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req)
        begin
            rsp_stall <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
            hold_req  = 1'b0;
        end
        else
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("FAIL");
            $finish;
        end
    end

    function automatic rxrb_pkg::req_item_t mk_item(rxrb_pkg::cmd_t c, logic [7:0] b,
                                                    logic [6:0] n);
        rxrb_pkg::req_item_t it;
        it.cmd     = c;
        it.rx_byte = b;
        it.max_len = n;
        return it;
    endfunction

    // Random command: pushes lean toward the terminator, lengths lean small
    function automatic rxrb_pkg::req_item_t rand_item(int push_pct, logic [7:0] term);
        rxrb_pkg::cmd_t c;
        logic [7:0]     b;
        logic [6:0]     n;
        int             sel;
        if ($urandom_range(99) < push_pct)
            c = rxrb_pkg::CMD_PUSH;
        else
        begin
            case ($urandom_range(2))
                0:       c = rxrb_pkg::CMD_READ;
                1:       c = rxrb_pkg::CMD_LINE;
                default: c = rxrb_pkg::CMD_STATUS;
            endcase
        end
        b   = ($urandom_range(3) == 0) ? term : 8'($urandom_range(255));
        sel = $urandom_range(9);
        if (sel < 7)
            n = 7'($urandom_range(8));
        else if (sel < 9)
            n = 7'($urandom_range(127));
        else
            n = 7'($urandom_range(127, 60));
        return mk_item(c, b, n);
    endfunction

    // Wait for the ring to go quiet, then write the terminator
    task automatic set_terminator(logic [7:0] term);
        while (cmd_feed_q.size() != 0 || ring_rsp_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= term;
        @(negedge clk);
        cfg_we    <= 1'b0;
        last_term = term;
        @(posedge clk);
    endtask

    initial
    begin
        shadow_head  = '0;
        shadow_held  = 0;
        shadow_terms = 0;
        shadow_term  = rxrb_pkg::TERM_RESET;
        snd_idle_pct = 19;
        rcv_idle_pct = 57;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty reads, field extremes, line stops, limit stops
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_STATUS, 8'h00, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_READ, 8'h00, 7'd127));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_LINE, 8'h00, 7'd5));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'h00, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'hFF, 7'd127));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'h0A, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'h41, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'h0A, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_STATUS, 8'hFF, 7'd127));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_READ, 8'h00, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_LINE, 8'h00, 7'd127));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_READ, 8'h00, 7'd1));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_LINE, 8'h00, 7'd3));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'h55, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'h66, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_LINE, 8'h00, 7'd64));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'h0A, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'h00, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'hFF, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'h0A, 7'd0));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_READ, 8'h00, 7'd2));
        cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_PUSH, 8'h00, 7'd0));

        // Random mix with bytes held across the terminator change
        set_terminator(8'h00);
        for (int i = 0; i < 12; i++)
            cmd_feed_q.push_back(rand_item(55, last_term));

        // Overfill so the oldest bytes get overwritten, then drain
        set_terminator(8'hFF);
        snd_idle_pct = 57;
        rcv_idle_pct = 19;
        for (int i = 0; i < 262; i++)
            cmd_feed_q.push_back(rand_item(100, last_term));
        for (int i = 0; i < 4; i++)
        begin
            cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_LINE, 8'($urandom_range(255)), 7'd127));
            cmd_feed_q.push_back(mk_item(rxrb_pkg::CMD_READ, 8'($urandom_range(255)), 7'd127));
        end

        // No idling; one long receiver hold-off while commands keep coming
        set_terminator(8'($urandom_range(254, 1)));
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req     = 1'b1;
        for (int i = 0; i < 24; i++)
            cmd_feed_q.push_back(rand_item(55, last_term));

        while (cmd_feed_q.size() != 0 || ring_rsp_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands and %0d responses (%0d data bytes), peak fill %0d,",
                 items_taken, rsp_seen, bytes_seen, peak_fill);
        $display("%0d oldest-byte overwrites, terminators 10/0/255/%0d, one %0d-cycle hold-off.",
                 overwrites, last_term, HOLD_CYCLES);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
